@@ rtl/utf8vd_pkg.sv @@
// utf8vd_pkg: shared types, status codes and checks for the UTF-8 decoder.
// No dependencies; every other file of the decoder but utf8vd_in_if imports it.
`timescale 1ns / 1ps

package utf8vd_pkg;

  localparam int unsigned CP_W = 21;
  localparam int unsigned ST_W = 3;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_BAD_LEAD  = 3'd1;
  localparam logic [ST_W-1:0] ST_TRUNC     = 3'd2;
  localparam logic [ST_W-1:0] ST_BAD_CONT  = 3'd3;
  localparam logic [ST_W-1:0] ST_OVERLONG  = 3'd4;
  localparam logic [ST_W-1:0] ST_SURROGATE = 3'd5;
  localparam logic [ST_W-1:0] ST_RANGE     = 3'd6;
  localparam logic [ST_W-1:0] ST_END_ERR   = 3'd7;

  localparam logic [CP_W-1:0] CP_MIN_2   = 21'h00080;
  localparam logic [CP_W-1:0] CP_MIN_3   = 21'h00800;
  localparam logic [CP_W-1:0] CP_MIN_4   = 21'h10000;
  localparam logic [CP_W-1:0] CP_SUR_LO  = 21'h0D800;
  localparam logic [CP_W-1:0] CP_SUR_HI  = 21'h0DFFF;
  localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;

  // How a byte reads when it opens a sequence
  typedef enum logic [2:0] {
    LK_ASCII    = 3'd0,
    LK_LEAD2    = 3'd1,
    LK_LEAD3    = 3'd2,
    LK_LEAD4    = 3'd3,
    LK_BAD_LEAD = 3'd4
  } lead_kind_t;

  // One classified byte as it travels through the queue
  typedef struct packed {
    lead_kind_t  lead_kind;
    logic [4:0]  lead_bits;  // payload bits of a lead byte, already masked
    logic [6:0]  low_bits;   // byte[6:0]; ASCII value, or [5:0] as continuation
    logic        cont_ok;    // byte has the 10xxxxxx form
    logic        eos;
  } cls_item_t;

  function automatic logic [ST_W-1:0] judge(input logic [CP_W-1:0] cp,
                                            input logic [2:0]      span);
    logic [ST_W-1:0] st;
    st = ST_OK;
    if ((span == 3'd2 && cp < CP_MIN_2) ||
        (span == 3'd3 && cp < CP_MIN_3) ||
        (span == 3'd4 && cp < CP_MIN_4)) begin
      st = ST_OVERLONG;
    end else if (cp >= CP_SUR_LO && cp <= CP_SUR_HI) begin
      st = ST_SURROGATE;
    end else if (cp > CP_MAX) begin
      st = ST_RANGE;
    end
    return st;
  endfunction

endpackage

@@ rtl/utf8vd_in_if.sv @@
// utf8vd_in_if: byte channel into the decoder (valid/ready plus payload).
// Depends on nothing beyond the standard widths of the byte stream.
`timescale 1ns / 1ps

interface utf8vd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

@@ rtl/utf8vd_out_if.sv @@
// utf8vd_out_if: result channel out of the decoder (valid/ready plus payload).
// Uses the field widths of utf8vd_pkg.
`timescale 1ns / 1ps

interface utf8vd_out_if;
  import utf8vd_pkg::*;
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic [ST_W-1:0] status;
  logic            last_of_string;

  modport source (output valid, output code_point, output status,
                  output last_of_string, input ready);
  modport sink   (input valid, input code_point, input status,
                  input last_of_string, output ready);
endinterface

@@ rtl/utf8vd_front.sv @@
// utf8vd_front: accepts input beats and classifies each byte for the back end.
// Depends on utf8vd_pkg and utf8vd_in_if.
`timescale 1ns / 1ps

module utf8vd_front (
  utf8vd_in_if.sink             in_ch,
  input  logic                  q_full,
  output logic                  push,
  output utf8vd_pkg::cls_item_t item
);
  import utf8vd_pkg::*;

  logic [7:0] b;
  assign b = in_ch.data_byte;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    item.lead_kind = LK_BAD_LEAD;
    item.lead_bits = '0;
    priority if (b[7] == 1'b0) begin
      item.lead_kind = LK_ASCII;
    end else if (b[7:5] == 3'b110) begin
      item.lead_kind = LK_LEAD2;
      item.lead_bits = b[4:0];
    end else if (b[7:4] == 4'b1110) begin
      item.lead_kind = LK_LEAD3;
      item.lead_bits = {1'b0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      item.lead_kind = LK_LEAD4;
      item.lead_bits = {2'b00, b[2:0]};
    end else begin
      item.lead_kind = LK_BAD_LEAD;
    end
    item.low_bits = b[6:0];
    item.cont_ok  = (b[7:6] == 2'b10);
    item.eos      = in_ch.end_of_string;
  end

endmodule

@@ rtl/utf8vd_queue.sv @@
// utf8vd_queue: short register queue of classified bytes between front and back.
// Depends on utf8vd_pkg for the item type.
`timescale 1ns / 1ps

module utf8vd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  utf8vd_pkg::cls_item_t push_item,
  input  logic                  pop,
  output logic                  full,
  output logic                  q_valid,
  output utf8vd_pkg::cls_item_t head
);
  import utf8vd_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cls_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign q_valid = (count_r != '0);
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ rtl/utf8vd_back.sv @@
// utf8vd_back: sequence assembly, validity checks and the result register.
// Depends on utf8vd_pkg and utf8vd_out_if.
`timescale 1ns / 1ps

module utf8vd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  utf8vd_pkg::cls_item_t item,
  output logic                  pop,
  utf8vd_out_if.source          out_ch
);
  import utf8vd_pkg::*;

  logic [1:0]      rem_r, rem_nxt;
  logic [2:0]      span_r, span_nxt;
  logic [CP_W-1:0] part_r, part_nxt;
  logic            pend_r, pend_nxt;
  logic            skip_r, skip_nxt;

  logic            ov_r, ov_nxt;
  logic [CP_W-1:0] ocp_r, ocp_nxt;
  logic [ST_W-1:0] ost_r, ost_nxt;
  logic            olast_r, olast_nxt;

  logic            emit;
  logic [ST_W-1:0] e_st;
  logic [CP_W-1:0] e_cp;
  logic [CP_W-1:0] acc;
  logic [1:0]      rem_dec;
  logic            pend_upd;

  assign pop = q_valid && (!ov_r || out_ch.ready);

  assign acc      = {part_r[CP_W-7:0], item.low_bits[5:0]};
  assign rem_dec  = rem_r - 2'd1;
  assign pend_upd = pend_r || !item.cont_ok;

  always_comb begin
    rem_nxt   = rem_r;
    span_nxt  = span_r;
    part_nxt  = part_r;
    pend_nxt  = pend_r;
    skip_nxt  = skip_r;
    emit      = 1'b0;
    e_st      = ST_OK;
    e_cp      = '0;

    if (pop) begin
      if (skip_r) begin
        if (item.eos) begin
          emit = 1'b1;
          e_st = ST_END_ERR;
        end
      end else if (rem_r == 2'd0) begin
        unique case (item.lead_kind)
          LK_ASCII: begin
            emit = 1'b1;
            e_cp = {{(CP_W-7){1'b0}}, item.low_bits};
          end
          LK_LEAD2, LK_LEAD3, LK_LEAD4: begin
            if (item.eos) begin
              emit = 1'b1;
              e_st = ST_TRUNC;
            end else begin
              unique case (item.lead_kind)
                LK_LEAD2: begin span_nxt = 3'd2; rem_nxt = 2'd1; end
                LK_LEAD3: begin span_nxt = 3'd3; rem_nxt = 2'd2; end
                default:  begin span_nxt = 3'd4; rem_nxt = 2'd3; end
              endcase
              part_nxt = {{(CP_W-5){1'b0}}, item.lead_bits};
              pend_nxt = 1'b0;
            end
          end
          default: begin
            emit = 1'b1;
            e_st = ST_BAD_LEAD;
          end
        endcase
      end else begin
        part_nxt = acc;
        pend_nxt = pend_upd;
        rem_nxt  = rem_dec;
        if (rem_dec == 2'd0) begin
          emit = 1'b1;
          e_st = pend_upd ? ST_BAD_CONT : judge(acc, span_r);
          e_cp = acc;
        end else if (item.eos) begin
          emit = 1'b1;
          e_st = ST_TRUNC;
        end
      end

      // Any result closes the sequence; an error on any byte but the end byte also starts skipping.
      if (emit && (item.eos || e_st != ST_OK || rem_r != 2'd0)) begin
        rem_nxt  = '0;
        span_nxt = '0;
        part_nxt = '0;
        pend_nxt = 1'b0;
        skip_nxt = !item.eos && (e_st != ST_OK);
      end
    end
  end

  always_comb begin
    ov_nxt    = ov_r && !out_ch.ready;
    ocp_nxt   = ocp_r;
    ost_nxt   = ost_r;
    olast_nxt = olast_r;
    if (emit) begin
      ov_nxt    = 1'b1;
      ocp_nxt   = (e_st == ST_OK) ? e_cp : '0;
      ost_nxt   = e_st;
      olast_nxt = item.eos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      span_r <= '0;
      part_r <= '0;
      pend_r <= 1'b0;
      skip_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      rem_r  <= rem_nxt;
      span_r <= span_nxt;
      part_r <= part_nxt;
      pend_r <= pend_nxt;
      skip_r <= skip_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ocp_r   <= ocp_nxt;
    ost_r   <= ost_nxt;
    olast_r <= olast_nxt;
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.code_point     = ocp_r;
  assign out_ch.status         = ost_r;
  assign out_ch.last_of_string = olast_r;

endmodule

@@ rtl/utf8vd_core.sv @@
// utf8_validating_decoder_core: top level of the UTF-8 to code point decoder.
// Depends on utf8vd_pkg, both channel interfaces, utf8vd_front, utf8vd_queue, utf8vd_back.
`timescale 1ns / 1ps

// The decoder takes one UTF-8 byte per beat on in_ch, with end_of_string on
// the final byte, and returns one beat on out_ch for each completed code point
// and for the first error of a string (bad lead, truncated, bad continuation,
// overlong, surrogate, out of range). After an error the rest of the string is
// dropped and its end byte yields an end-after-error beat. Throughput is one
// byte per clock while out_ch is not stalled, as the back end's sequence
// register steps on each byte it takes from the queue. A byte passes through
// the queue, then the back end loads its result into the result register,
// which presents the beat on out_ch until it is taken. A stall on out_ch backs
// up into the QUEUE_DEPTH-entry queue before in_ch.ready drops. No clearing
// pass is needed after reset.
module utf8_validating_decoder_core #(
  parameter int unsigned QUEUE_DEPTH = 2   // classified-byte queue entries, 2..32
) (
  input  logic          clk,
  input  logic          rst_n,
  utf8vd_in_if.sink     in_ch,
  utf8vd_out_if.source  out_ch
);
  import utf8vd_pkg::*;

  // front end -> queue
  cls_item_t front_item;
  logic      push;
  logic      q_full;

  // queue -> back end
  cls_item_t head;
  logic      q_valid;
  logic      pop;

  // Front: handshake on the byte side, classify the byte as lead or continuation.
  utf8vd_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .item   (front_item)
  );

  // Decouples input acceptance from output stalls.
  utf8vd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .full      (q_full),
    .q_valid   (q_valid),
    .head      (head)
  );

  // Back: assemble sequences, run the checks in order, hold the result beat.
  utf8vd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .item    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

  // Error beats never carry a code point.
  a_err_cp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_OK) |-> (out_ch.code_point == '0))
    else $error("error beat with nonzero code point");

  // An ok beat is a legal scalar value.
  a_ok_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_OK) |->
      (out_ch.code_point <= CP_MAX &&
       (out_ch.code_point < CP_SUR_LO || out_ch.code_point > CP_SUR_HI)))
    else $error("ok beat with illegal code point");

  // End-after-error only ever closes a string.
  a_end_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_END_ERR) |-> out_ch.last_of_string)
    else $error("end-after-error beat without last_of_string");

  // A waiting entry with a free result register is consumed that cycle.
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && (!out_ch.valid || out_ch.ready)) |-> pop)
    else $error("back end idles with work queued");

endmodule

@@ tb/utf8vd_decode_checker.sv @@
// utf8vd_decode_checker: watches both decoder channels, predicts each result
// beat from the accepted bytes and compares them field by field.
// Depends on utf8vd_pkg and the two channel interfaces.
`timescale 1ns / 1ps

module utf8vd_decode_checker (
  input  logic        clk,
  input  logic        rst_n,
  utf8vd_in_if        in_ch,
  utf8vd_out_if       out_ch,
  output int unsigned failures,
  output int unsigned awaited,
  output int unsigned beats_checked,
  output int unsigned error_beats
);
  import utf8vd_pkg::*;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic [ST_W-1:0] status;
    logic            last_of_string;
  } cp_result_t;

  cp_result_t expected_cps[$];

  // decoder state as the predictor sees it
  logic [1:0]      need_more   = '0;
  logic [2:0]      seq_span    = '0;
  logic [CP_W-1:0] cp_acc      = '0;
  logic            cont_broken = 1'b0;
  logic            dropping    = 1'b0;

  int unsigned fail_total  = 0;
  int unsigned wait_total  = 0;
  int unsigned check_total = 0;
  int unsigned err_total   = 0;

  assign failures      = fail_total;
  assign awaited       = wait_total;
  assign beats_checked = check_total;
  assign error_beats   = err_total;

  // overlong first, then surrogate, then beyond the top code point
  function automatic logic [ST_W-1:0] grade_value(input logic [CP_W-1:0] cp,
                                                  input logic [2:0]      span);
    logic [CP_W-1:0] floor_cp;
    case (span)
      3'd2:    floor_cp = CP_MIN_2;
      3'd3:    floor_cp = CP_MIN_3;
      3'd4:    floor_cp = CP_MIN_4;
      default: floor_cp = '0;
    endcase
    if (cp < floor_cp) return ST_OVERLONG;
    if (cp >= CP_SUR_LO && cp <= CP_SUR_HI) return ST_SURROGATE;
    if (cp > CP_MAX) return ST_RANGE;
    return ST_OK;
  endfunction

  task automatic clear_decode();
    need_more   = '0;
    seq_span    = '0;
    cp_acc      = '0;
    cont_broken = 1'b0;
    dropping    = 1'b0;
  endtask

  task automatic record_result(input logic [CP_W-1:0] cp, input logic [ST_W-1:0] st,
                               input logic last);
    cp_result_t beat;
    beat.code_point     = (st == ST_OK) ? cp : '0;
    beat.status         = st;
    beat.last_of_string = last;
    expected_cps = {expected_cps, beat};
    if (last) begin
      clear_decode();
    end else if (st != ST_OK) begin
      clear_decode();
      dropping = 1'b1;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eos);
    logic [2:0]      span;
    logic [4:0]      lead_bits;
    logic [ST_W-1:0] st;
    logic [CP_W-1:0] cp;
    if (dropping) begin
      if (eos) record_result('0, ST_END_ERR, 1'b1);
      return;
    end
    if (need_more == 2'd0) begin
      if (b[7] == 1'b0) begin
        record_result({14'd0, b[6:0]}, ST_OK, eos);
        return;
      end else if (b[7:5] == 3'b110) begin
        span = 3'd2; lead_bits = b[4:0];
      end else if (b[7:4] == 4'b1110) begin
        span = 3'd3; lead_bits = {1'b0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        span = 3'd4; lead_bits = {2'b00, b[2:0]};
      end else begin
        record_result('0, ST_BAD_LEAD, eos);
        return;
      end
      if (eos) begin
        record_result('0, ST_TRUNC, 1'b1);
        return;
      end
      seq_span    = span;
      need_more   = 2'(span - 3'd1);
      cp_acc      = {16'd0, lead_bits};
      cont_broken = 1'b0;
      return;
    end
    // continuation position; a malformed byte is only flagged for now
    if (b[7:6] != 2'b10) cont_broken = 1'b1;
    cp_acc    = {cp_acc[CP_W-7:0], b[5:0]};
    need_more = need_more - 2'd1;
    if (need_more == 2'd0) begin
      st = cont_broken ? ST_BAD_CONT : grade_value(cp_acc, seq_span);
      cp = cp_acc;
      clear_decode();
      record_result(cp, st, eos);
    end else if (eos) begin
      record_result('0, ST_TRUNC, 1'b1);
    end
  endtask

  always @(posedge clk) begin : watch
    cp_result_t got;
    cp_result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.code_point     = out_ch.code_point;
        got.status         = out_ch.status;
        got.last_of_string = out_ch.last_of_string;
        if (expected_cps.size() == 0) begin
          $error("unexpected result beat: code_point 0x%06h status %0d last %0b",
                 got.code_point, got.status, got.last_of_string);
          fail_total++;
        end else begin
          want = expected_cps.pop_front();
          if (got.code_point !== want.code_point) begin
            $error("code_point mismatch: expected 0x%06h, actual 0x%06h",
                   want.code_point, got.code_point);
            fail_total++;
          end
          if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            fail_total++;
          end
          if (got.last_of_string !== want.last_of_string) begin
            $error("last_of_string mismatch: expected %0b, actual %0b",
                   want.last_of_string, got.last_of_string);
            fail_total++;
          end
          check_total++;
          if (want.status != ST_OK) err_total++;
        end
      end
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.data_byte, in_ch.end_of_string);
      wait_total = expected_cps.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
// tb_top: stimulus and verdict for utf8_validating_decoder_core.
// Depends on utf8vd_pkg, both channel interfaces, the core and utf8vd_decode_checker.
`timescale 1ns / 1ps

module tb_top;
  import utf8vd_pkg::*;

  localparam int unsigned RANDOM_BYTES = 1525;
  // Slowest legal run, with the longest source gap and sink stall on every beat,
  // stays far below this limit; this leaves a wide margin.
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  // quiet window after the last awaited result, in which strays would show
  localparam int unsigned DRAIN_CYCLES = 16;

  // Directed strings, {end_of_string, byte} per beat.
  localparam logic [8:0] DIRECTED [27] = '{
    9'h000, 9'h17F,                         // ASCII extremes, last on the end byte
    9'h0C2, 9'h1A9,                         // plain two-byte form
    9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,         // top code point, span closes on end byte
    9'h0C0, 9'h180,                         // overlong, error on the end byte
    9'h0ED, 9'h0A0, 9'h080, 9'h1FF,         // surrogate, then end mark while dropping
    9'h0F4, 9'h090, 9'h080, 9'h080, 9'h141, // beyond the top code point, dropped tail
    9'h0E2, 9'h141,                         // bad continuation cut short: truncated wins
    9'h1F0,                                 // lead byte that is also the end byte
    9'h180,                                 // stray continuation as lead on the end byte
    9'h0E2, 9'h0C1, 9'h082, 9'h141          // bad continuation held until span closes
  };

  logic clk;
  logic rst_n;

  utf8vd_in_if  in_ch();
  utf8vd_out_if out_ch();

  int unsigned failures;
  int unsigned awaited;
  int unsigned beats_checked;
  int unsigned error_beats;

  int unsigned cycles       = 0;
  int unsigned bytes_sent   = 0;
  int unsigned strings_sent = 0;

  // idle bursts: each side flips into a no-gap stretch now and then
  logic src_calm = 1'b0;
  logic snk_calm = 1'b0;

  logic [7:0] string_bytes[$];

  utf8_validating_decoder_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  utf8vd_decode_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .failures      (failures),
    .awaited       (awaited),
    .beats_checked (beats_checked),
    .error_beats   (error_beats)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Every input known from time zero.
  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = '0;
    in_ch.end_of_string = 1'b0;
    out_ch.ready        = 1'b0;
  end

  // Runaway guard.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycles, awaited);
      $display("status: fail");
      $finish;
    end
  end

  // One beat on in_ch. Called at a falling edge, returns at a falling edge.
  // valid is written once per step, so back-to-back beats keep it high.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int unsigned gap;
    if ($urandom_range(0, 49) == 0) src_calm = !src_calm;
    gap = src_calm ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= b;
    in_ch.end_of_string <= eos;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic append_byte(input logic [7:0] b);
    string_bytes = {string_bytes, b};
  endtask

  // Appends cp in a span-byte form; a span larger than needed makes an overlong.
  task automatic add_encoded(input logic [20:0] cp, input int unsigned span);
    case (span)
      1: append_byte({1'b0, cp[6:0]});
      2: begin
        append_byte({3'b110, cp[10:6]});
        append_byte({2'b10, cp[5:0]});
      end
      3: begin
        append_byte({4'b1110, cp[15:12]});
        append_byte({2'b10, cp[11:6]});
        append_byte({2'b10, cp[5:0]});
      end
      default: begin
        append_byte({5'b11110, cp[20:18]});
        append_byte({2'b10, cp[17:12]});
        append_byte({2'b10, cp[11:6]});
        append_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // One character of a random string: mostly well-formed, some malformed on purpose.
  task automatic add_char();
    int unsigned pick;
    int unsigned span;
    int unsigned idx;
    logic [20:0] cp;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      add_encoded(21'($urandom_range(0, 'h7F)), 1);
    end else if (pick < 55) begin
      add_encoded(21'($urandom_range('h80, 'h7FF)), 2);
    end else if (pick < 70) begin
      cp = 21'($urandom_range('h800, 'hFFFF));
      if (cp >= CP_SUR_LO && cp <= CP_SUR_HI) cp = cp ^ 21'h02000;
      add_encoded(cp, 3);
    end else if (pick < 80) begin
      add_encoded(21'($urandom_range('h10000, 'h10FFFF)), 4);
    end else if (pick < 83) begin
      // overlong in any multi-byte span
      span = $urandom_range(2, 4);
      case (span)
        2:       cp = 21'($urandom_range(0, 'h7F));
        3:       cp = 21'($urandom_range(0, 'h7FF));
        default: cp = 21'($urandom_range(0, 'hFFFF));
      endcase
      add_encoded(cp, span);
    end else if (pick < 85) begin
      add_encoded(21'($urandom_range(CP_SUR_LO, CP_SUR_HI)), 3);
    end else if (pick < 87) begin
      add_encoded(21'($urandom_range('h110000, 'h1FFFFF)), 4);
    end else if (pick < 90) begin
      // bad lead: stray continuation or an F8..FF byte
      b = $urandom_range(0, 1) ? 8'($urandom_range('h80, 'hBF))
                               : 8'($urandom_range('hF8, 'hFF));
      append_byte(b);
    end else if (pick < 93) begin
      // well-formed sequence with one continuation byte spoiled
      span = $urandom_range(2, 4);
      case (span)
        2:       add_encoded(21'($urandom_range('h80, 'h7FF)), 2);
        3:       add_encoded(21'($urandom_range('hE000, 'hFFFF)), 3);
        default: add_encoded(21'($urandom_range('h10000, 'h10FFFF)), 4);
      endcase
      idx = string_bytes.size() - $urandom_range(1, span - 1);
      b = 8'($urandom_range(0, 255));
      if (b[7:6] == 2'b10) b[6] = 1'b1;
      string_bytes[idx] = b;
    end else if (pick < 95) begin
      // lead with its continuations missing
      append_byte(8'($urandom_range('hC0, 'hF7)));
    end else begin
      append_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_string();
    int unsigned n;
    n = string_bytes.size();
    for (int unsigned i = 0; i < n; i++) send_byte(string_bytes[i], i == n - 1);
    strings_sent++;
  endtask

  // Result sink: random stalls before each beat, with stall-free stretches.
  initial begin : sink
    int unsigned stall;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) snk_calm = !snk_calm;
      stall = snk_calm ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int unsigned random_start;
    int unsigned keep;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED[i]) begin
      send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
      if (DIRECTED[i][8]) strings_sent++;
    end

    // Random strings; some are cut short so the end mark lands mid-sequence.
    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      string_bytes.delete();
      repeat ($urandom_range(1, 8)) add_char();
      if ($urandom_range(0, 99) < 15 && string_bytes.size() > 1) begin
        keep = $urandom_range(1, string_bytes.size() - 1);
        string_bytes = string_bytes[0:keep-1];
      end
      send_string();
    end
    in_ch.valid <= 1'b0;

    // drain: every expectation met, then a short quiet window for strays
    while (awaited != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d bytes in %0d strings; %0d result beats compared, %0d of them errors",
             bytes_sent, strings_sent, beats_checked, error_beats);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", failures);
      $display("status: fail");
    end
    $finish;
  end

endmodule
